// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define MHPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mhpq assertion failed");

// next-cycle implication, disabled while reset is held
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mhpq assertion failed");

`endif

// File: rtl/mhpq_pkg.sv
// shared types and constants of the min-heap priority queue
package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int FILL_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_PEEK    = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  // broadcast control for the row of cells
  typedef struct packed {
    cell_op_t                 op;
    logic signed [KEY_W-1:0]  key;
  } cell_ctrl_t;

endpackage

// File: rtl/mhpq_if.sv
// request and result channel interfaces of the min-heap priority queue
interface mhpq_in_if import mhpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [KEY_W-1:0] key_in;

  modport source (output valid, output opcode, output key_in, input ready);
  modport sink   (input valid, input opcode, input key_in, output ready);
endinterface

interface mhpq_out_if import mhpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_out;
  logic [STAT_W-1:0]       status;
  logic [FILL_W-1:0]       fill_count;

  modport source (output valid, output key_out, output status, output fill_count,
                  input ready);
  modport sink   (input valid, input key_out, input status, input fill_count,
                  output ready);
endinterface

// File: rtl/mhpq_cell.sv
// one slot of the sorted key row: keep, take the new key or shift
module mhpq_cell import mhpq_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic                    occupied,
  input  logic signed [KEY_W-1:0] key_left,
  input  logic                    le_left,
  input  logic signed [KEY_W-1:0] key_right,
  output logic signed [KEY_W-1:0] key_o,
  output logic                    le_o
);

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;

  // slot is occupied and its held key is no larger than the incoming one
  assign le_o  = occupied && (key_r <= ctrl.key);
  assign key_o = key_r;

  // insert shifts larger keys right, remove shifts everything left
  always_comb begin
    unique case (ctrl.op)
      CELL_HOLD:   key_nxt = key_r;
      CELL_INSERT: key_nxt = le_o ? key_r : (le_left ? ctrl.key : key_left);
      CELL_REMOVE: key_nxt = key_right;
      default:     key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// File: rtl/mhpq_chain.sv
// row of cells that keeps the held keys in ascending order
module mhpq_chain import mhpq_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]        count,
  output logic signed [KEY_W-1:0] head_key
);

  logic signed [KEY_W-1:0] key_row [CAPACITY];
  logic [CAPACITY-1:0]     le_row;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                    occ;
      logic signed [KEY_W-1:0] k_left;
      logic                    l_left;
      logic signed [KEY_W-1:0] k_right;

      // slot is in use when below the element count
      assign occ = CNT_W'(gi) < count;

      if (gi == 0) begin : g_first
        assign k_left = ctrl.key;
        assign l_left = 1'b0;
      end else begin : g_mid
        assign k_left = key_row[gi-1];
        assign l_left = le_row[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign k_right = '0;
      end else begin : g_inner
        assign k_right = key_row[gi+1];
      end

      mhpq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (occ),
        .key_left  (k_left),
        .le_left   (l_left),
        .key_right (k_right),
        .key_o     (key_row[gi]),
        .le_o      (le_row[gi])
      );
    end
  endgenerate

  assign head_key = key_row[0];

endmodule

// File: rtl/min_heap_priority_queue_core.sv
// top level of the min-heap priority queue
//
//   channel  | dir | handshake          | payload
//   in_chan  | in  | valid / ready      | opcode, key_in
//   out_chan | out | valid / ready      | key_out, status, fill_count
//
// one request per cycle unless stalled: the row of cells sorts in the accept
// cycle and the result appears in the output register on the next cycle
// a new request is taken while the output register is empty or being drained
// a stalled result holds in_chan.ready low until it is taken
// rst_n clears the element count and the output valid; cell keys are not reset
module min_heap_priority_queue_core import mhpq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mhpq_in_if.sink    in_chan,
  mhpq_out_if.source out_chan
);

  logic                    accept;
  op_t                     op;
  logic                    full;
  logic                    empty;
  cell_ctrl_t              ctrl;
  logic signed [KEY_W-1:0] head_key;
  logic signed [KEY_W-1:0] res_key;
  stat_t                   res_stat;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic signed [KEY_W-1:0] key_out_r;
  stat_t                   status_r;
  logic [FILL_W-1:0]       fill_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign op            = op_t'(in_chan.opcode);
  assign full          = count_r == CNT_W'(CAPACITY);
  assign empty         = count_r == '0;

  // decode the request into cell control and a result
  always_comb begin
    ctrl.op   = CELL_HOLD;
    ctrl.key  = in_chan.key_in;
    res_key   = '0;
    res_stat  = STAT_OK;
    count_nxt = count_r;
    if (accept) begin
      unique case (op)
        OP_INSERT: begin
          if (full) begin
            res_stat = STAT_FULL;
          end else begin
            ctrl.op   = CELL_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_PEEK: begin
          if (empty) begin
            res_stat = STAT_EMPTY;
          end else begin
            res_key = head_key;
          end
        end
        OP_EXTRACT: begin
          if (empty) begin
            res_stat = STAT_EMPTY;
          end else begin
            res_key   = head_key;
            ctrl.op   = CELL_REMOVE;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_NOP: begin
          res_stat = STAT_OK;
        end
      endcase
    end
  end

  mhpq_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .count    (count_r),
    .head_key (head_key)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      key_out_r <= res_key;
      status_r  <= res_stat;
      fill_r    <= FILL_W'(count_nxt);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.key_out    = key_out_r;
  assign out_chan.status     = status_r;
  assign out_chan.fill_count = fill_r;

endmodule

// File: rtl/mhpq_checker.sv
// port-level checks of the min-heap priority queue and their binding
`include "assert_macros.svh"

module mhpq_checker import mhpq_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [KEY_W-1:0] key_out,
  input logic [STAT_W-1:0]       status,
  input logic [FILL_W-1:0]       fill_count
);

  // a stalled result stays offered
  `MHPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // an empty output register always takes a request
  `MHPQ_ASSERT_IMPLY(a_ready_when_free, clk, rst_n, !out_valid, in_ready)

  // a full rejection reports a full heap
  `MHPQ_ASSERT_IMPLY(a_full_count, clk, rst_n,
    out_valid && (status == STAT_FULL), fill_count == FILL_W'(CAPACITY))

  // an empty rejection reports no keys and a zero key
  `MHPQ_ASSERT_IMPLY(a_empty_result, clk, rst_n,
    out_valid && (status == STAT_EMPTY), (fill_count == '0) && (key_out == '0))

  // the count never passes the capacity
  `MHPQ_ASSERT_IMPLY(a_count_range, clk, rst_n, out_valid,
    fill_count <= FILL_W'(CAPACITY))

endmodule

bind min_heap_priority_queue_core mhpq_checker u_mhpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .key_out    (out_chan.key_out),
  .status     (out_chan.status),
  .fill_count (out_chan.fill_count)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the min-heap priority queue core
module tb_top;
  import mhpq_pkg::*;

  localparam int RANDOM_REQS    = 400;
  localparam int HOLD_OFF       = 300;
  localparam int HOLD_AFTER     = 150;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 200000;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  // expected fields of one result
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    stat_t                   stat;
    logic [FILL_W-1:0]       fill;
  } heap_result_t;

  // one directed request, with a hand-written result where typed is set
  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic                    typed;
    heap_result_t            res;
  } script_row_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  localparam int SCRIPT_LEN = 24;

  // directed requests: empty reads, no-ops, extremes, ties, drain to empty
  script_row_t script_rows [SCRIPT_LEN] = '{
    '{OP_PEEK,    32'sd0,  1'b1, '{32'sd0, STAT_EMPTY, 7'd0}},
    '{OP_EXTRACT, 32'sd0,  1'b1, '{32'sd0, STAT_EMPTY, 7'd0}},
    '{OP_NOP,     32'sd0,  1'b1, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_NOP,     -32'sd1, 1'b1, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_INSERT,  KEY_MAX, 1'b1, '{32'sd0, STAT_OK,    7'd1}},
    '{OP_PEEK,    32'sd0,  1'b1, '{KEY_MAX, STAT_OK,   7'd1}},
    '{OP_INSERT,  KEY_MIN, 1'b1, '{32'sd0, STAT_OK,    7'd2}},
    '{OP_PEEK,    -32'sd1, 1'b1, '{KEY_MIN, STAT_OK,   7'd2}},
    '{OP_INSERT,  32'sd0,  1'b1, '{32'sd0, STAT_OK,    7'd3}},
    '{OP_INSERT,  -32'sd1, 1'b1, '{32'sd0, STAT_OK,    7'd4}},
    '{OP_INSERT,  32'sd5,  1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_INSERT,  32'sd5,  1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_INSERT,  -32'sd1, 1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_PEEK,    32'sd0,  1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_EXTRACT, 32'sd0,  1'b1, '{KEY_MIN, STAT_OK,   7'd6}},
    '{OP_EXTRACT, KEY_MAX, 1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_EXTRACT, 32'sd0,  1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_EXTRACT, 32'sd0,  1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_NOP,     32'sd3,  1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_EXTRACT, 32'sd0,  1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_EXTRACT, 32'sd0,  1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_EXTRACT, 32'sd0,  1'b0, '{32'sd0, STAT_OK,    7'd0}},
    '{OP_EXTRACT, 32'sd0,  1'b1, '{32'sd0, STAT_EMPTY, 7'd0}},
    '{OP_PEEK,    KEY_MIN, 1'b1, '{32'sd0, STAT_EMPTY, 7'd0}}
  };

  logic clk;
  logic rst_n;

  mhpq_in_if  in_bus ();
  mhpq_out_if out_bus ();

  min_heap_priority_queue_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // shadow heap of the predictor
  logic signed [KEY_W-1:0] heap_keys [CAPACITY];
  int                      heap_fill;

  heap_result_t pending_results [$];
  int error_count;
  int requests_sent;
  int results_seen;
  int full_rejects;
  int empty_reads;
  int peak_fill;
  int cycle_count;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("tb_top: timeout after %0d cycles, %0d results still due",
               cycle_count, pending_results.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input longint exp_val,
                                 input longint got_val);
    $display("tb_top: mismatch in %s at result %0d: expected %0d, got %0d",
             what, results_seen, exp_val, got_val);
    error_count++;
  endtask

  // heap behavior: one request in, one result out, shadow heap updated
  function automatic heap_result_t heap_predict(input op_t op,
                                                input logic signed [KEY_W-1:0] key);
    heap_result_t            r;
    int                      pos;
    int                      parent;
    int                      lchild;
    int                      rchild;
    int                      best;
    logic signed [KEY_W-1:0] tmp;
    r.key  = '0;
    r.stat = STAT_OK;
    case (op)
      OP_INSERT: begin
        if (heap_fill >= CAPACITY) begin
          r.stat = STAT_FULL;
        end else begin
          heap_keys[heap_fill] = key;
          pos = heap_fill;
          heap_fill++;
          // sift up while strictly below the parent
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!(heap_keys[pos] < heap_keys[parent])) break;
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[parent];
            heap_keys[parent] = tmp;
            pos = parent;
          end
        end
      end
      OP_PEEK: begin
        if (heap_fill == 0) r.stat = STAT_EMPTY;
        else r.key = heap_keys[0];
      end
      OP_EXTRACT: begin
        if (heap_fill == 0) begin
          r.stat = STAT_EMPTY;
        end else begin
          r.key = heap_keys[0];
          heap_keys[0] = heap_keys[heap_fill-1];
          heap_fill--;
          // sift down toward the smaller child, left wins a tie
          pos = 0;
          forever begin
            lchild = 2 * pos + 1;
            rchild = 2 * pos + 2;
            best = pos;
            if (lchild < heap_fill && heap_keys[lchild] < heap_keys[best]) best = lchild;
            if (rchild < heap_fill && heap_keys[rchild] < heap_keys[best]) best = rchild;
            if (best == pos) break;
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = tmp;
            pos = best;
          end
        end
      end
      default: ;
    endcase
    r.fill = FILL_W'(heap_fill);
    return r;
  endfunction

  // offer one request after a random gap and log its result once taken
  task automatic send_request(input op_t op, input logic signed [KEY_W-1:0] key,
                              input logic typed, input heap_result_t typed_res);
    int           gap;
    int           pick;
    heap_result_t predicted;
    pick = $urandom_range(0, 19);
    if (pick < 12) gap = 0;
    else if (pick < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.opcode <= op;
    in_bus.key_in <= key;
    do @(posedge clk); while (!in_bus.ready);
    predicted = heap_predict(op, key);
    pending_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
  endtask

  // request side: reset, directed table, then random mixes
  initial begin : request_source
    int                      seg;
    int                      seg_len;
    int                      pick;
    mix_t                    mix;
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    heap_result_t            no_res;
    no_res         = '{32'sd0, STAT_OK, 7'd0};
    heap_fill      = 0;
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.opcode <= OP_NOP;
    in_bus.key_in <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script_rows[i])
      send_request(script_rows[i].op, script_rows[i].key, script_rows[i].typed,
                   script_rows[i].res);

    // random segments: the first one is insert-heavy, to drive the heap to full
    seg = 0;
    while (requests_sent < SCRIPT_LEN + RANDOM_REQS) begin
      mix     = (seg == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      seg_len = (seg == 0) ? 90 : $urandom_range(20, 80);
      for (int j = 0; j < seg_len; j++) begin
        pick = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  op = (pick < 85) ? OP_INSERT : (pick < 90) ? OP_PEEK :
                          (pick < 97) ? OP_EXTRACT : OP_NOP;
          MIX_DRAIN: op = (pick < 15) ? OP_INSERT : (pick < 22) ? OP_PEEK :
                          (pick < 97) ? OP_EXTRACT : OP_NOP;
          default:   op = (pick < 45) ? OP_INSERT : (pick < 60) ? OP_PEEK :
                          (pick < 97) ? OP_EXTRACT : OP_NOP;
        endcase
        // mostly full-range keys, some clustered for ties, a few extremes
        pick = $urandom_range(0, 9);
        if (pick == 0) key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        else if (pick < 3) key = $signed($urandom_range(0, 15)) - 8;
        else key = $urandom;
        send_request(op, key, 1'b0, no_res);
      end
      seg++;
    end
    in_bus.valid <= 1'b0;

    // let every result drain, then wait out the DRAIN_CYCLES quiet period
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d requests, %0d results checked, peak fill %0d",
             requests_sent, results_seen, peak_fill);
    $display("tb_top: %0d full rejects, %0d empty reads, one %0d-cycle result stall",
             full_rejects, empty_reads, HOLD_OFF);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to back up the input
  initial begin : result_sink
    int   run;
    logic held;
    held = 1'b0;
    out_bus.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && requests_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        for (int c = 0; c < HOLD_OFF; c++) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      out_bus.ready <= 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      repeat (run) @(posedge clk);
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    heap_result_t exp_res;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("tb_top: unexpected result key %0d status %0d fill %0d",
                 out_bus.key_out, out_bus.status, out_bus.fill_count);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_bus.key_out !== exp_res.key)
          report_mismatch("key_out", longint'(exp_res.key), longint'(out_bus.key_out));
        if (out_bus.status !== exp_res.stat)
          report_mismatch("status", longint'(exp_res.stat), longint'(out_bus.status));
        if (out_bus.fill_count !== exp_res.fill)
          report_mismatch("fill_count", longint'(exp_res.fill),
                          longint'(out_bus.fill_count));
        if (exp_res.stat == STAT_FULL) full_rejects++;
        if (exp_res.stat == STAT_EMPTY) empty_reads++;
        if (int'(exp_res.fill) > peak_fill) peak_fill = int'(exp_res.fill);
      end
      results_seen++;
    end
  end

endmodule

// File: files.f
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_if.sv
rtl/mhpq_cell.sv
rtl/mhpq_chain.sv
rtl/min_heap_priority_queue_core.sv
rtl/mhpq_checker.sv
tb/tb_top.sv
